/* hw/rtl/bss_pkg.sv */
// bss_pkg: shared types, codes and defaults of the bounded subset sum selector
// no dependencies
`timescale 1ns / 1ps

package bss_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int PICK_LIMIT_DEF  = 10;
  localparam int LENGTH_BITS_DEF = 20;
  localparam int TARGET_BITS     = 29;
  localparam int PICK_BITS       = 4;
  localparam logic [PICK_BITS-1:0] MAX_PICK_RESET = 4'd5;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FOUND = 3'd0,
    ST_BELOW = 3'd1,
    ST_ABOVE = 3'd2,
    ST_NOSOL = 3'd3,
    ST_FULL  = 3'd4,
    ST_EMPTY = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LRD,
    S_LCMP,
    S_CHK,
    S_MIN,
    S_BUILD,
    S_NEWN,
    S_ENTER,
    S_E3,
    S_L1,
    S_L1B,
    S_DUP,
    S_L2,
    S_L3A,
    S_L3B,
    S_FAIL,
    S_OUT,
    S_OUT2,
    S_ERR
  } state_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    last;
  } res_ctl_t;

endpackage

/* hw/rtl/bss_ifs.sv */
// bss channel interfaces: request, response and configuration write
// depends on bss_pkg
`timescale 1ns / 1ps

interface bss_req_if import bss_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  op_t                    operation;
  logic [LENGTH_BITS-1:0] block_length;
  logic [TARGET_BITS-1:0] target_length;
  modport source (output valid, operation, block_length, target_length, input ready);
  modport sink (input valid, operation, block_length, target_length, output ready);
endinterface

interface bss_rsp_if import bss_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int RANK_BITS   = 9
);
  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [LENGTH_BITS-1:0] chosen_length;
  logic [RANK_BITS-1:0]   chosen_rank;
  logic                   last;
  modport source (output valid, status, chosen_length, chosen_rank, last, input ready);
  modport sink (input valid, status, chosen_length, chosen_rank, last, output ready);
endinterface

interface bss_cfg_if import bss_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [PICK_BITS-1:0] max_pick;
  modport source (output valid, max_pick, input ready);
  modport sink (input valid, max_pick, output ready);
endinterface

/* hw/rtl/bss_ram.sv */
// bss_ram: single write port, single read port memory, registered read data
// no dependencies
`timescale 1ns / 1ps

module bss_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bss_ctrl.sv */
// bss_ctrl: sorted table upkeep, prefix sum build and depth-first search sequencer
// depends on bss_pkg, bss_ifs and bss_ram
`timescale 1ns / 1ps

module bss_ctrl import bss_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PICK_LIMIT  = PICK_LIMIT_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  bss_req_if.sink                          req,
  input  logic [PICK_BITS-1:0]             max_pick,
  input  logic                             res_ready,
  output res_ctl_t                         res,
  output logic [LENGTH_BITS-1:0]           res_length,
  output logic [$clog2(TABLE_DEPTH)-1:0]   res_rank
);

  localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_BITS  = LENGTH_BITS + CNT_BITS;
  localparam int WIDE      = SUM_BITS > TARGET_BITS ? SUM_BITS : TARGET_BITS;
  localparam int D_BITS    = $clog2(PICK_LIMIT + 2);
  localparam int K_BITS    = $clog2(PICK_LIMIT > 1 ? PICK_LIMIT : 2);
  localparam int IW        = (CNT_BITS > D_BITS ? CNT_BITS : D_BITS) + 1;
  localparam int LW        = PICK_BITS + 1;

  state_t state, state_next;

  logic [CNT_BITS-1:0]    count;
  logic [SUM_BITS-1:0]    total;
  logic [LENGTH_BITS-1:0] vin;
  logic [CNT_BITS-1:0]    pos;
  logic [TARGET_BITS-1:0] target;
  logic [D_BITS-1:0]      n;
  logic [D_BITS-1:0]      d;
  logic [CNT_BITS-1:0]    start;
  logic [CNT_BITS-1:0]    j;
  logic [WIDE-1:0]        rem;
  logic [LENGTH_BITS-1:0] v;
  logic [SUM_BITS-1:0]    ptmp;
  logic [CNT_BITS-1:0]    bi;
  logic [SUM_BITS-1:0]    acc;
  status_t                err_st;

  logic [CNT_BITS-1:0]    jstk [PICK_LIMIT];
  logic [CNT_BITS-1:0]    sstk [PICK_LIMIT];
  logic [WIDE-1:0]        rstk [PICK_LIMIT];

  logic                   len_we, len_re, pre_we, pre_re;
  logic [ADDR_BITS-1:0]   len_waddr, len_raddr;
  logic [LENGTH_BITS-1:0] len_wdata, len_rdata;
  logic [CNT_BITS-1:0]    pre_waddr, pre_raddr;
  logic [SUM_BITS-1:0]    pre_wdata, pre_rdata;

  logic [D_BITS-1:0]      left;
  logic [IW-1:0]          cnt_w, left_w, start_w, j_w;
  logic [LW-1:0]          lim;
  logic [K_BITS-1:0]      sidx;
  logic [CNT_BITS-1:0]    s_j;
  logic [CNT_BITS-1:0]    s_start;
  logic [WIDE-1:0]        s_rem;
  logic [WIDE-1:0]        v_w, rd_w, tgt_w, tot_w, span_w;

  bss_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(LENGTH_BITS)) u_len (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  bss_ram #(.DEPTH(TABLE_DEPTH + 1), .WIDTH(SUM_BITS)) u_pre (
    .clk   (clk),
    .we    (pre_we),
    .waddr (pre_waddr),
    .wdata (pre_wdata),
    .re    (pre_re),
    .raddr (pre_raddr),
    .rdata (pre_rdata)
  );

  assign left    = n - d;
  assign cnt_w   = IW'(count);
  assign left_w  = IW'(left);
  assign start_w = IW'(start);
  assign j_w     = IW'(j);
  assign lim     = ({1'b0, max_pick} > LW'(PICK_LIMIT)) ? LW'(PICK_LIMIT) : {1'b0, max_pick};
  assign sidx    = (state == S_FAIL) ? K_BITS'(d - 1'b1) : K_BITS'(d);
  assign s_j     = jstk[sidx];
  assign s_start = sstk[sidx];
  assign s_rem   = rstk[sidx];
  assign v_w     = WIDE'(v);
  assign rd_w    = WIDE'(len_rdata);
  assign tgt_w   = WIDE'(target);
  assign tot_w   = WIDE'(total);
  assign span_w  = WIDE'(total - pre_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    res        = '{valid: 1'b0, status: ST_FOUND, last: 1'b0};
    res_length = '0;
    res_rank   = '0;
    len_we     = 1'b0;
    len_waddr  = '0;
    len_wdata  = vin;
    len_re     = 1'b0;
    len_raddr  = '0;
    pre_we     = 1'b0;
    pre_waddr  = '0;
    pre_wdata  = '0;
    pre_re     = 1'b0;
    pre_raddr  = '0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.operation)
            OP_LOAD: begin
              state_next = (count == CNT_BITS'(TABLE_DEPTH)) ? S_ERR : S_LRD;
            end
            OP_SEARCH: state_next = S_CHK;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_LRD: begin
        if (pos == '0) begin
          len_we     = 1'b1;
          len_waddr  = '0;
          state_next = S_IDLE;
        end else begin
          len_re     = 1'b1;
          len_raddr  = ADDR_BITS'(pos - 1'b1);
          state_next = S_LCMP;
        end
      end
      S_LCMP: begin
        len_we    = 1'b1;
        len_waddr = ADDR_BITS'(pos);
        if (len_rdata < vin) begin
          len_wdata  = len_rdata;
          state_next = S_LRD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHK: begin
        if (count == '0) begin
          state_next = S_ERR;
        end else begin
          len_re     = 1'b1;
          len_raddr  = ADDR_BITS'(count - 1'b1);
          state_next = S_MIN;
        end
      end
      S_MIN: begin
        if (tgt_w < rd_w || tgt_w > tot_w) begin
          state_next = S_ERR;
        end else begin
          pre_we     = 1'b1;
          pre_waddr  = '0;
          pre_wdata  = '0;
          len_re     = 1'b1;
          len_raddr  = '0;
          state_next = S_BUILD;
        end
      end
      S_BUILD: begin
        pre_we    = 1'b1;
        pre_waddr = bi + 1'b1;
        pre_wdata = acc + SUM_BITS'(len_rdata);
        if (bi + 1'b1 == count) begin
          state_next = S_NEWN;
        end else begin
          len_re    = 1'b1;
          len_raddr = ADDR_BITS'(bi + 1'b1);
        end
      end
      S_NEWN: begin
        state_next = (LW'(n) > lim) ? S_ERR : S_ENTER;
      end
      S_ENTER: begin
        if (left == '0) begin
          state_next = (rem == '0) ? S_OUT : S_FAIL;
        end else if (start_w + left_w > cnt_w) begin
          state_next = S_FAIL;
        end else begin
          pre_re     = 1'b1;
          pre_raddr  = CNT_BITS'(cnt_w - left_w);
          state_next = S_E3;
        end
      end
      S_E3: begin
        state_next = (span_w > rem) ? S_FAIL : S_L1;
      end
      S_L1: begin
        if (j_w + left_w > cnt_w) begin
          state_next = S_FAIL;
        end else begin
          len_re     = 1'b1;
          len_raddr  = ADDR_BITS'(j);
          state_next = S_L1B;
        end
      end
      S_L1B: begin
        if (j != start) begin
          len_re     = 1'b1;
          len_raddr  = ADDR_BITS'(j - 1'b1);
          state_next = S_DUP;
        end else begin
          state_next = S_L2;
        end
      end
      S_DUP: begin
        state_next = (len_rdata == v) ? S_L1 : S_L2;
      end
      S_L2: begin
        if (v_w > rem) begin
          state_next = S_L1;
        end else begin
          pre_re     = 1'b1;
          pre_raddr  = CNT_BITS'(j_w + left_w);
          state_next = S_L3A;
        end
      end
      S_L3A: begin
        pre_re     = 1'b1;
        pre_raddr  = j;
        state_next = S_L3B;
      end
      S_L3B: begin
        state_next = (WIDE'(ptmp - pre_rdata) < rem) ? S_FAIL : S_ENTER;
      end
      S_FAIL: begin
        state_next = (d == '0) ? S_NEWN : S_L1;
      end
      S_OUT: begin
        len_re     = 1'b1;
        len_raddr  = ADDR_BITS'(s_j);
        state_next = S_OUT2;
      end
      S_OUT2: begin
        res        = '{valid: 1'b1, status: ST_FOUND, last: (d == n - 1'b1)};
        res_length = len_rdata;
        res_rank   = ADDR_BITS'(s_j);
        if (res_ready) begin
          state_next = (d == n - 1'b1) ? S_IDLE : S_OUT;
        end
      end
      S_ERR: begin
        res = '{valid: 1'b1, status: err_st, last: 1'b1};
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control counters of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid && req.operation == OP_CLEAR) begin
            count <= '0;
            total <= '0;
          end
        end
        S_LRD: begin
          if (pos == '0) begin
            count <= count + 1'b1;
            total <= total + SUM_BITS'(vin);
          end
        end
        S_LCMP: begin
          if (len_rdata >= vin) begin
            count <= count + 1'b1;
            total <= total + SUM_BITS'(vin);
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of load and search
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        vin    <= req.block_length;
        pos    <= count;
        target <= req.target_length;
        err_st <= ST_FULL;
      end
      S_LCMP: begin
        if (len_rdata < vin) begin
          pos <= pos - 1'b1;
        end
      end
      S_CHK: err_st <= ST_EMPTY;
      S_MIN: begin
        err_st <= (tgt_w < rd_w) ? ST_BELOW : ST_ABOVE;
        bi     <= '0;
        acc    <= '0;
        n      <= D_BITS'(1);
      end
      S_BUILD: begin
        acc <= acc + SUM_BITS'(len_rdata);
        bi  <= bi + 1'b1;
      end
      S_NEWN: begin
        err_st <= ST_NOSOL;
        d      <= '0;
        start  <= '0;
        rem    <= tgt_w;
      end
      S_ENTER: begin
        if (left == '0) begin
          d <= '0;
        end
      end
      S_E3: j <= start;
      S_L1B: v <= len_rdata;
      S_DUP: begin
        if (len_rdata == v) begin
          j <= j + 1'b1;
        end
      end
      S_L2: begin
        if (v_w > rem) begin
          j <= j + 1'b1;
        end
      end
      S_L3A: ptmp <= pre_rdata;
      S_L3B: begin
        jstk[K_BITS'(d)] <= j;
        sstk[K_BITS'(d)] <= start;
        rstk[K_BITS'(d)] <= rem;
        d     <= d + 1'b1;
        start <= j + 1'b1;
        rem   <= rem - v_w;
      end
      S_FAIL: begin
        if (d == '0) begin
          n <= n + 1'b1;
        end else begin
          d     <= d - 1'b1;
          j     <= s_j + 1'b1;
          start <= s_start;
          rem   <= s_rem;
        end
      end
      S_OUT2: begin
        if (res_ready) begin
          d <= d + 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(TABLE_DEPTH))
    else $error("table count beyond depth");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_L1 || state == S_L2 || state == S_L3B) |-> d < n)
    else $error("search depth not below pick size");

  a_found_in_out: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_FOUND) |-> $past(state) == S_OUT || $past(state) == S_OUT2)
    else $error("found result outside output walk");

  a_load_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_LCMP && len_rdata >= vin) |=> count == $past(count) + 1'b1)
    else $error("finished load did not bump count");

endmodule

/* hw/rtl/bounded_subset_sum_selector.sv */
// bounded_subset_sum_selector: top level, configuration register and response register
// depends on bss_pkg, bss_ifs, bss_ram and bss_ctrl
//
//   port  role     carries
//   req   sink     operation, block_length, target_length
//   rsp   source   status, chosen_length, chosen_rank, last
//   cfg   sink     max_pick
//
// a load shifts each smaller entry up one place after the accept, then writes the new length
// a search runs the checks and the prefix sum pass, then the search steps, each step bound
// by the one read port of the length and prefix memories
// req.ready is high only while no request is at work; rsp holds one result in a register
// synchronous active high reset empties the table and sets max_pick to 5, no clearing pass
`timescale 1ns / 1ps

module bounded_subset_sum_selector import bss_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PICK_LIMIT  = PICK_LIMIT_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  bss_req_if.sink  req,
  bss_rsp_if.source rsp,
  bss_cfg_if.sink  cfg
);

  localparam int RANK_BITS = $clog2(TABLE_DEPTH);

  logic [PICK_BITS-1:0]   max_pick;
  res_ctl_t               res;
  logic [LENGTH_BITS-1:0] res_length;
  logic [RANK_BITS-1:0]   res_rank;
  logic                   res_ready;
  logic                   o_valid;

  assign cfg.ready = 1'b1;
  assign res_ready = !o_valid || rsp.ready;
  assign rsp.valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pick <= MAX_PICK_RESET;
    end else if (cfg.valid) begin
      max_pick <= cfg.max_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (res_ready) begin
      o_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      rsp.status        <= res.status;
      rsp.chosen_length <= res_length;
      rsp.chosen_rank   <= res_rank;
      rsp.last          <= res.last;
    end
  end

  bss_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PICK_LIMIT  (PICK_LIMIT),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .max_pick   (max_pick),
    .res_ready  (res_ready),
    .res        (res),
    .res_length (res_length),
    .res_rank   (res_rank)
  );

endmodule

/* tb/tb_bss_scoreboard.sv */
// scoreboard for the bounded subset sum selector: table predictor and result check
// depends on bss_pkg
`timescale 1ns / 1ps

package tb_bss_scoreboard_pkg;
  import bss_pkg::*;

  typedef struct {
    status_t     status;
    logic [19:0] chosen_length;
    logic [8:0]  chosen_rank;
    logic        last;
  } pick_result_t;

  class bss_scoreboard;
    logic [19:0]  lengths[TABLE_DEPTH_DEF];
    int           count;
    longint       total;
    int           max_pick;
    int           ranks[PICK_LIMIT_DEF];
    longint       sums[TABLE_DEPTH_DEF + 1];
    pick_result_t pending_q[$];
    int           errors;

    function new();
      count = 0;
      total = 0;
      max_pick = MAX_PICK_RESET;
      errors = 0;
      foreach (ranks[i]) ranks[i] = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void push_status(status_t st);
      pick_result_t r;
      r.status = st;
      r.chosen_length = '0;
      r.chosen_rank = '0;
      r.last = 1'b1;
      pending_q.push_back(r);
    endfunction

    function bit seek(int start, int left, longint rem, int depth);
      longint v;
      if (left == 0) return rem == 0;
      if (start + left > count) return 0;
      if (sums[count] - sums[count - left] > rem) return 0;
      for (int j = start; j + left <= count; j++) begin
        v = lengths[j];
        if (j > start && lengths[j] == lengths[j-1]) continue;
        if (v > rem) continue;
        if (sums[j + left] - sums[j] < rem) return 0;
        if (depth < PICK_LIMIT_DEF) ranks[depth] = j;
        if (seek(j + 1, left - 1, rem - v, depth + 1)) return 1;
      end
      return 0;
    endfunction

    function void search(longint target);
      int limit;
      pick_result_t r;
      if (count == 0) begin
        push_status(ST_EMPTY);
        return;
      end
      if (target < lengths[count-1]) begin
        push_status(ST_BELOW);
        return;
      end
      if (target > total) begin
        push_status(ST_ABOVE);
        return;
      end
      sums[0] = 0;
      for (int i = 0; i < count; i++) sums[i+1] = sums[i] + lengths[i];
      limit = max_pick > PICK_LIMIT_DEF ? PICK_LIMIT_DEF : max_pick;
      for (int n = 1; n <= limit; n++) begin
        if (seek(0, n, target, 0)) begin
          for (int i = 0; i < n; i++) begin
            r.status = ST_FOUND;
            r.chosen_length = lengths[ranks[i]];
            r.chosen_rank = 9'(ranks[i]);
            r.last = (i + 1 == n);
            pending_q.push_back(r);
          end
          return;
        end
      end
      push_status(ST_NOSOL);
    endfunction

    function void note_request(op_t op, logic [19:0] blen, logic [28:0] tlen);
      int pos;
      case (op)
        OP_CLEAR: begin
          count = 0;
          total = 0;
        end
        OP_LOAD: begin
          if (count >= TABLE_DEPTH_DEF) begin
            push_status(ST_FULL);
          end else begin
            pos = count;
            while (pos > 0 && lengths[pos-1] < blen) begin
              lengths[pos] = lengths[pos-1];
              pos--;
            end
            lengths[pos] = blen;
            count++;
            total += blen;
          end
        end
        OP_SEARCH: search(tlen);
        default: ;
      endcase
    endfunction

    task check_result(status_t st, logic [19:0] clen, logic [8:0] crank, logic lst);
      pick_result_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result status %0d", st));
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status)
        report($sformatf("status %0d, want %0d", st, e.status));
      if (clen !== e.chosen_length)
        report($sformatf("chosen_length %0d, want %0d", clen, e.chosen_length));
      if (crank !== e.chosen_rank)
        report($sformatf("chosen_rank %0d, want %0d", crank, e.chosen_rank));
      if (lst !== e.last)
        report($sformatf("last %0d, want %0d", lst, e.last));
    endtask
  endclass
endpackage

/* tb/tb_top.sv */
// top level testbench of bounded_subset_sum_selector: directed and random requests,
// random stalls on both sides; depends on bss_pkg, bss_ifs and tb_bss_scoreboard
`timescale 1ns / 1ps

module tb_top;
  import bss_pkg::*;
  import tb_bss_scoreboard_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;
  int   hold_req = 0;
  int   hold_left = 0;
  int   sent = 0;
  bss_scoreboard sb;

  bss_req_if req_ch ();
  bss_rsp_if rsp_ch ();
  bss_cfg_if cfg_ch ();

  bounded_subset_sum_selector dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, one long hold, check on accept
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.status, rsp_ch.chosen_length, rsp_ch.chosen_rank,
                        rsp_ch.last);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  task send(op_t op, logic [19:0] blen, logic [28:0] tlen);
    while (!calm && $urandom_range(99) < 12) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.block_length <= blen;
    req_ch.target_length <= tlen;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, blen, tlen);
    sent++;
  endtask

  task drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0 || !req_ch.ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_pick(logic [3:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_pick <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.max_pick = value;
  endtask

  task search_round(int searches);
    int k;
    longint tsum;
    for (int s = 0; s < searches; s++) begin
      k = $urandom_range(5);
      tsum = 0;
      case (k)
        0, 1, 2: for (int i = 0; i < sb.count; i++)
          if ($urandom_range(2) == 0) tsum += sb.lengths[i];
        3: tsum = $urandom_range(32'(sb.total + 2));
        4: tsum = sb.total + $urandom_range(1);
        default: tsum = (sb.count > 0 && sb.lengths[sb.count-1] > 0) ?
                        sb.lengths[sb.count-1] - 1 : $urandom;
      endcase
      send(OP_SEARCH, 20'($urandom), tsum[28:0]);
    end
  endtask

  initial begin
    logic [19:0] v;
    int n;
    sb = new();
    req_ch.valid = 1'b0;
    req_ch.operation = OP_CLEAR;
    req_ch.block_length = '0;
    req_ch.target_length = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_pick = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send(OP_SEARCH, '0, 29'd5);
    send(OP_LOAD, 20'hFFFFF, '0);
    send(OP_LOAD, 20'd7, '0);
    send(OP_LOAD, 20'd100, '0);
    send(OP_LOAD, 20'd7, '0);
    send(OP_LOAD, 20'h80000, '0);
    send(OP_SEARCH, '0, 29'd6);
    send(OP_SEARCH, '0, 29'h1FFFFFFF);
    send(OP_SEARCH, '0, 29'd107);
    send(OP_SEARCH, '0, 29'd14);
    send(OP_SEARCH, '0, 29'd8);
    send(OP_NONE, 20'hFFFFF, 29'h1FFFFFFF);
    send(OP_SEARCH, '0, 29'h17FFFE + 29'd114);
    write_pick(4'd1);
    send(OP_SEARCH, '0, 29'd114);
    write_pick(4'd0);
    send(OP_SEARCH, '0, 29'd7);
    write_pick(4'd15);
    send(OP_SEARCH, '0, 29'h17FFFF + 29'd114);
    send(OP_CLEAR, '0, '0);
    send(OP_LOAD, 20'd0, '0);
    send(OP_SEARCH, '0, 29'd0);
    send(OP_CLEAR, '0, '0);
    write_pick(4'd10);

    // random phases
    for (int ph = 0; sent < 170; ph++) begin
      calm = (ph >= 3 && ph < 6);
      if (ph % 4 == 2) write_pick(4'($urandom_range(15)));
      if (ph == 7) write_pick(4'd10);
      send(OP_CLEAR, 20'($urandom), 29'($urandom));
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        v = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(1, 40));
        send(OP_LOAD, v, 29'($urandom));
        if ($urandom_range(15) == 0) send(OP_NONE, 20'($urandom), 29'($urandom));
      end
      if (ph == 4) hold_req = 400;
      search_round($urandom_range(3, 7));
      if (ph == 5) drain();
      if ($urandom_range(9) == 0) send(OP_SEARCH, 20'($urandom), 29'($urandom));
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/bss_pkg.sv
hw/rtl/bss_ifs.sv
hw/rtl/bss_ram.sv
hw/rtl/bss_ctrl.sv
hw/rtl/bounded_subset_sum_selector.sv
tb/tb_bss_scoreboard.sv
tb/tb_top.sv
